FILE: rtl/core/pwmt_pkg.sv
// Shared types and constants for the PWM frame bit transmitter.
// No dependencies.
package pwmt_pkg;

  localparam int unsigned DefTickWidth = 16;
  localparam int unsigned DurW         = 16;
  localparam int unsigned NumRegs      = 5;
  localparam int unsigned CfgIdxW      = 3;
  localparam int unsigned CmdDepth     = 2;
  localparam int unsigned SegW         = 5;

  localparam int unsigned RstBitPeriod = 24;
  localparam int unsigned RstHighOne   = 8;
  localparam int unsigned RstHighZero  = 16;
  localparam int unsigned RstSofHigh   = 32;
  localparam int unsigned RstSofLow    = 16;

  // segment numbering: 0 SOF high, 1 SOF low, 2..17 bit high/low pairs
  localparam logic [SegW-1:0] SofHighSeg  = 5'd0;
  localparam logic [SegW-1:0] FirstBitSeg = 5'd2;
  localparam logic [SegW-1:0] LastSeg     = 5'd17;

  typedef enum logic [CfgIdxW-1:0] {
    RegBitPeriod = 3'd0,
    RegHighOne   = 3'd1,
    RegHighZero  = 3'd2,
    RegSofHigh   = 3'd3,
    RegSofLow    = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic            line_level;
    logic [DurW-1:0] duration_ticks;
    logic            frame_end;
    logic            last_of_run;
  } out_item_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
    logic       sof;
  } cmd_t;

endpackage

FILE: rtl/core/pwmt_cfg_regs.sv
// Timing configuration registers of the PWM transmitter.
// Depends on pwmt_pkg.
module pwmt_cfg_regs #(
  parameter int unsigned TICK_WIDTH = pwmt_pkg::DefTickWidth
) (
  input  logic                                            clk_i,
  input  logic                                            rst_ni,
  input  logic                                            cfg_we_i,
  input  logic [pwmt_pkg::CfgIdxW-1:0]                    cfg_idx_i,
  input  logic [TICK_WIDTH-1:0]                           cfg_wdata_i,
  output logic [pwmt_pkg::NumRegs-1:0][TICK_WIDTH-1:0]    cfg_o
);
  import pwmt_pkg::*;

  logic [NumRegs-1:0][TICK_WIDTH-1:0] regs_q, regs_d;

  always_comb begin
    regs_d = regs_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        RegBitPeriod: regs_d[RegBitPeriod] = cfg_wdata_i;
        RegHighOne:   regs_d[RegHighOne]   = cfg_wdata_i;
        RegHighZero:  regs_d[RegHighZero]  = cfg_wdata_i;
        RegSofHigh:   regs_d[RegSofHigh]   = cfg_wdata_i;
        RegSofLow:    regs_d[RegSofLow]    = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q[RegBitPeriod] <= TICK_WIDTH'(RstBitPeriod);
      regs_q[RegHighOne]   <= TICK_WIDTH'(RstHighOne);
      regs_q[RegHighZero]  <= TICK_WIDTH'(RstHighZero);
      regs_q[RegSofHigh]   <= TICK_WIDTH'(RstSofHigh);
      regs_q[RegSofLow]    <= TICK_WIDTH'(RstSofLow);
    end else begin
      regs_q <= regs_d;
    end
  end

  assign cfg_o = regs_q;

endmodule

FILE: rtl/core/pwmt_front.sv
// Front end: accepts bytes, tags frame starts, buffers them in a short queue.
// Depends on pwmt_pkg.
module pwmt_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  pwmt_pkg::in_item_t in_item_i,
  output logic               cmd_valid_o,
  output pwmt_pkg::cmd_t     cmd_o,
  input  logic               cmd_pop_i
);
  import pwmt_pkg::*;

  localparam int unsigned PtrW = $clog2(CmdDepth);
  localparam int unsigned CntW = $clog2(CmdDepth + 1);

  cmd_t            mem_q [CmdDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            in_frame_q, in_frame_d;
  logic            wr_en, rd_en;
  cmd_t            wr_cmd;

  assign full        = (cnt_q == CntW'(CmdDepth));
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = mem_q[rd_ptr_q];

  assign wr_en = push && !full;
  assign rd_en = cmd_pop_i && cmd_valid_o;

  always_comb begin
    wr_cmd.data_byte = in_item_i.data_byte;
    wr_cmd.last_byte = in_item_i.last_byte;
    wr_cmd.sof       = !in_frame_q;

    in_frame_d = in_frame_q;
    wr_ptr_d   = wr_ptr_q;
    rd_ptr_d   = rd_ptr_q;
    cnt_d      = cnt_q;
    if (wr_en) begin
      in_frame_d = !in_item_i.last_byte;
      wr_ptr_d   = wr_ptr_q + PtrW'(1);
    end
    if (rd_en) begin
      rd_ptr_d = rd_ptr_q + PtrW'(1);
    end
    case ({wr_en, rd_en})
      2'b10:   cnt_d = cnt_q + CntW'(1);
      2'b01:   cnt_d = cnt_q - CntW'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q <= 1'b0;
      wr_ptr_q   <= '0;
      rd_ptr_q   <= '0;
      cnt_q      <= '0;
    end else begin
      in_frame_q <= in_frame_d;
      wr_ptr_q   <= wr_ptr_d;
      rd_ptr_q   <= rd_ptr_d;
      cnt_q      <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= wr_cmd;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(CmdDepth))
    else $error("command queue count overflow");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0) |-> !rd_en)
    else $error("command queue popped while empty");

  a_frame_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |=> (in_frame_q == !$past(in_item_i.last_byte)))
    else $error("frame tracking lost");

endmodule

FILE: rtl/core/pwmt_back.sv
// Back end: sequencer, one segment per cycle into an output register unless held.
// Depends on pwmt_pkg.
module pwmt_back #(
  parameter int unsigned TICK_WIDTH = pwmt_pkg::DefTickWidth
) (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  input  logic [pwmt_pkg::NumRegs-1:0][TICK_WIDTH-1:0] cfg_i,
  input  logic                                         cmd_valid_i,
  input  pwmt_pkg::cmd_t                               cmd_i,
  output logic                                         cmd_pop_o,
  output logic                                         empty,
  input  logic                                         pop,
  output pwmt_pkg::out_item_t                          out_item_o
);
  import pwmt_pkg::*;

  localparam int unsigned ExtW = (TICK_WIDTH > DurW) ? TICK_WIDTH : DurW;

  logic            busy_q, busy_d;
  logic [SegW-1:0] seg_q, seg_d;
  cmd_t            cmd_q;
  logic            out_valid_q, out_valid_d;
  out_item_t       out_q, seg_item;

  logic            out_ready, emit, load, at_last;
  logic [SegW-1:0] seg_rel;
  logic [2:0]      bit_idx;
  logic            bit_val;
  logic [TICK_WIDTH-1:0] hi, period, lo, dur;
  logic [ExtW-1:0] dur_ext;

  assign out_ready = !out_valid_q || pop;
  assign emit      = busy_q && out_ready;
  assign at_last   = (seg_q == LastSeg);
  assign load      = cmd_valid_i && (!busy_q || (emit && at_last));
  assign cmd_pop_o = load;

  always_comb begin
    seg_rel = seg_q - FirstBitSeg;
    bit_idx = ~seg_rel[3:1];
    bit_val = cmd_q.data_byte[bit_idx];
    hi      = bit_val ? cfg_i[RegHighOne] : cfg_i[RegHighZero];
    period  = cfg_i[RegBitPeriod];
    lo      = (period > hi) ? (period - hi) : '0;

    if (seg_q == SofHighSeg) begin
      dur = cfg_i[RegSofHigh];
    end else if (seg_q < FirstBitSeg) begin
      dur = cfg_i[RegSofLow];
    end else if (!seg_q[0]) begin
      dur = hi;
    end else begin
      dur = lo;
    end
    dur_ext = ExtW'(dur);

    seg_item.line_level     = !seg_q[0];
    seg_item.duration_ticks = dur_ext[DurW-1:0];
    seg_item.last_of_run    = at_last;
    seg_item.frame_end      = at_last && cmd_q.last_byte;
  end

  always_comb begin
    busy_d      = busy_q;
    seg_d       = seg_q;
    out_valid_d = out_valid_q;
    if (emit) begin
      seg_d       = seg_q + SegW'(1);
      out_valid_d = 1'b1;
      if (at_last) begin
        busy_d = 1'b0;
      end
    end else if (pop && out_valid_q) begin
      out_valid_d = 1'b0;
    end
    if (load) begin
      busy_d = 1'b1;
      seg_d  = cmd_i.sof ? SofHighSeg : FirstBitSeg;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      seg_q       <= FirstBitSeg;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      seg_q       <= seg_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      cmd_q <= cmd_i;
    end
    if (emit) begin
      out_q <= seg_item;
    end
  end

  assign empty      = !out_valid_q;
  assign out_item_o = out_q;

  a_seg_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (seg_q <= LastSeg))
    else $error("segment counter out of range");

  a_sof_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && cmd_i.sof) |=> (busy_q && seg_q == SofHighSeg))
    else $error("frame start did not begin with start-of-frame segment");

  a_end_is_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.last_of_run) |-> !out_q.line_level)
    else $error("byte ended on a high segment");

  a_frame_end_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.frame_end) |-> out_q.last_of_run)
    else $error("frame end off a byte boundary");

endmodule

FILE: rtl/core/pwm_frame_bit_transmitter.sv
// PWM frame bit transmitter: byte queue front end, segment sequencer back end.
// Depends on pwmt_pkg, pwmt_cfg_regs, pwmt_front, pwmt_back.
//
// Each pushed byte becomes sixteen line segments (high then low per bit, MSB
// first), or eighteen when it opens a frame and the start-of-frame high and
// low segments go first. The segment sequencer produces one segment per clock
// while the output register is empty or popped, and back-to-back bytes stream
// without gaps; a two-entry byte queue sits in front of it, so full rises only
// when the queue holds two bytes. The first segment passes the byte queue, the
// sequencer state and the output register. After reset the timing registers
// hold period 24, one-high 8, zero-high 16, SOF high 32, SOF low 16; change
// them only while no transfer is in flight.
module pwm_frame_bit_transmitter #(
  parameter int unsigned TICK_WIDTH = pwmt_pkg::DefTickWidth
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push,
  output logic                          full,
  input  pwmt_pkg::in_item_t            in_item_i,
  output logic                          empty,
  input  logic                          pop,
  output pwmt_pkg::out_item_t           out_item_o,
  input  logic                          cfg_we_i,
  input  logic [pwmt_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [TICK_WIDTH-1:0]         cfg_wdata_i
);
  import pwmt_pkg::*;

  logic [NumRegs-1:0][TICK_WIDTH-1:0] cfg;
  logic cmd_valid, cmd_pop;
  cmd_t cmd;

  pwmt_cfg_regs #(
    .TICK_WIDTH (TICK_WIDTH)
  ) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  pwmt_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .in_item_i   (in_item_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  pwmt_back #(
    .TICK_WIDTH (TICK_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .empty       (empty),
    .pop         (pop),
    .out_item_o  (out_item_o)
  );

endmodule

FILE: verif/pwm_frame_bit_transmitter_test.sv
// Self-checking testbench for pwm_frame_bit_transmitter: byte transfers in, line segments out.
// Depends on pwmt_pkg and the pwm_frame_bit_transmitter RTL; a scoreboard class predicts
// every segment from the timing registers and the frame state.
module pwm_frame_bit_transmitter_test;
  timeunit 1ns;
  timeprecision 1ps;

  import pwmt_pkg::*;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned HoldCycles = 400;

  class pwm_segment_board;
    logic [DurW-1:0] timing[NumRegs];
    bit              in_frame;
    out_item_t       expected_segs[$];
    int unsigned     errors;
    int unsigned     segs_checked;
    int unsigned     frames_closed;

    function new();
      timing[RegBitPeriod] = DurW'(RstBitPeriod);
      timing[RegHighOne]   = DurW'(RstHighOne);
      timing[RegHighZero]  = DurW'(RstHighZero);
      timing[RegSofHigh]   = DurW'(RstSofHigh);
      timing[RegSofLow]    = DurW'(RstSofLow);
      in_frame = 1'b0;
    endfunction

    function void set_reg(logic [CfgIdxW-1:0] idx, logic [DurW-1:0] val);
      if (idx < NumRegs) begin
        timing[idx] = val;
      end
    endfunction

    function void add_seg(logic level, logic [DurW-1:0] dur, logic fend, logic lrun);
      out_item_t seg;
      seg.line_level     = level;
      seg.duration_ticks = dur;
      seg.frame_end      = fend;
      seg.last_of_run    = lrun;
      expected_segs.push_back(seg);
    endfunction

    // Expected segments for one accepted byte.
    function void note_byte(in_item_t item);
      logic [DurW-1:0] hi;
      logic [DurW-1:0] lo;
      if (!in_frame) begin
        add_seg(1'b1, timing[RegSofHigh], 1'b0, 1'b0);
        add_seg(1'b0, timing[RegSofLow], 1'b0, 1'b0);
        in_frame = 1'b1;
      end
      for (int i = 7; i >= 0; i--) begin
        hi = item.data_byte[i] ? timing[RegHighOne] : timing[RegHighZero];
        lo = (timing[RegBitPeriod] > hi) ? timing[RegBitPeriod] - hi : '0;
        add_seg(1'b1, hi, 1'b0, 1'b0);
        add_seg(1'b0, lo, (i == 0) && item.last_byte, i == 0);
      end
      if (item.last_byte) begin
        in_frame = 1'b0;
        frames_closed++;
      end
    endfunction

    function void check_segment(out_item_t got);
      out_item_t exp_seg;
      if (expected_segs.size() == 0) begin
        errors++;
        $display("%0t: unexpected segment lvl=%0b dur=%0d fend=%0b lrun=%0b", $time,
                 got.line_level, got.duration_ticks, got.frame_end, got.last_of_run);
        return;
      end
      exp_seg = expected_segs.pop_front();
      segs_checked++;
      if (got.line_level !== exp_seg.line_level ||
          got.duration_ticks !== exp_seg.duration_ticks ||
          got.frame_end !== exp_seg.frame_end ||
          got.last_of_run !== exp_seg.last_of_run) begin
        errors++;
        $display("%0t: segment mismatch exp lvl=%0b dur=%0d fend=%0b lrun=%0b", $time,
                 exp_seg.line_level, exp_seg.duration_ticks, exp_seg.frame_end,
                 exp_seg.last_of_run);
        $display("%0t:                  got lvl=%0b dur=%0d fend=%0b lrun=%0b", $time,
                 got.line_level, got.duration_ticks, got.frame_end, got.last_of_run);
      end
    endfunction

    function int unsigned waiting();
      return expected_segs.size();
    endfunction
  endclass

  logic                 clk_i     = 1'b0;
  logic                 rst_ni    = 1'b0;
  logic                 push      = 1'b0;
  logic                 full;
  in_item_t             in_item_i = '0;
  logic                 empty;
  logic                 pop       = 1'b0;
  out_item_t            out_item_o;
  logic                 cfg_we_i  = 1'b0;
  logic [CfgIdxW-1:0]   cfg_idx_i = '0;
  logic [DurW-1:0]      cfg_wdata_i = '0;

  pwm_frame_bit_transmitter dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .in_item_i   (in_item_i),
    .empty       (empty),
    .pop         (pop),
    .out_item_o  (out_item_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  pwm_segment_board board = new();

  bit          hold_req;
  bit          saw_backpressure;
  int unsigned bytes_sent;
  int unsigned settings_used;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("pwm_frame_bit_transmitter regression: fail");
    $finish;
  end

  // Result side: checks each transfer, pops on a shifting pattern, long hold on request.
  initial begin : drain
    int unsigned mode;
    int unsigned mode_left;
    int unsigned hold_left;
    int unsigned tick;
    mode      = 0;
    mode_left = 0;
    hold_left = 0;
    tick      = 0;
    forever begin
      @(posedge clk_i);
      if (pop && !empty) begin
        board.check_segment(out_item_o);
      end
      tick++;
      if (hold_req && hold_left == 0) begin
        hold_req  = 1'b0;
        hold_left = HoldCycles;
      end
      if (hold_left != 0) begin
        hold_left--;
        if (full) begin
          saw_backpressure = 1'b1;
        end
        pop <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 3);
          mode_left = $urandom_range(10, 80);
        end
        mode_left--;
        case (mode)
          0: pop <= 1'b1;
          1: pop <= 1'($urandom_range(0, 1));
          2: pop <= (tick % 4 == 0);
          default: pop <= ($urandom_range(0, 9) == 0);
        endcase
      end
    end
  end

  task automatic send_byte(input logic [7:0] data, input logic last);
    in_item_t item;
    item.data_byte = data;
    item.last_byte = last;
    push      <= 1'b1;
    in_item_i <= item;
    do @(posedge clk_i); while (full);
    board.note_byte(item);
    bytes_sent++;
  endtask

  task automatic settle();
    push <= 1'b0;
    while (board.waiting() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic put_reg(input logic [CfgIdxW-1:0] idx, input logic [DurW-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    board.set_reg(idx, val);
  endtask

  // Writes all timing registers plus one write to an unused index.
  task automatic load_timing(input logic [DurW-1:0] period, input logic [DurW-1:0] h_one,
                             input logic [DurW-1:0] h_zero, input logic [DurW-1:0] sof_hi,
                             input logic [DurW-1:0] sof_lo);
    put_reg(RegBitPeriod, period);
    put_reg(RegHighOne, h_one);
    put_reg(RegHighZero, h_zero);
    put_reg(CfgIdxW'(NumRegs + $urandom_range(0, 2)), DurW'($urandom));
    put_reg(RegSofHigh, sof_hi);
    put_reg(RegSofLow, sof_lo);
    cfg_we_i <= 1'b0;
    settings_used++;
  endtask

  function automatic logic [DurW-1:0] pick_ticks();
    case ($urandom_range(0, 6))
      0:       return '0;
      1:       return '1;
      2, 3:    return DurW'($urandom_range(1, 40));
      default: return DurW'($urandom);
    endcase
  endfunction

  task automatic run_bytes(input int unsigned count, input bit gaps, input bit press);
    int unsigned burst_left;
    int unsigned gap;
    burst_left = $urandom_range(1, 12);
    for (int unsigned n = 0; n < count; n++) begin
      if (press && n == 4) begin
        hold_req = 1'b1;
      end
      send_byte(8'($urandom), $urandom_range(0, 3) == 0);
      burst_left--;
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 12);
        gap = $urandom_range(0, 5);
        if (gaps && gap != 0) begin
          push <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
    end
  endtask

  initial begin : stimulus
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset timing: single-byte frame, then multi-byte frames
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h01, 1'b1);
    send_byte(8'hA5, 1'b0);
    send_byte(8'h5A, 1'b0);
    send_byte(8'hC3, 1'b1);
    settle();

    // widest durations, zero-high equal to the period, empty SOF low
    load_timing('1, 16'd1, '1, '1, '0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'h7E, 1'b1);
    settle();

    // high longer than the period, zero-length highs
    load_timing(16'd10, '0, 16'd20, '0, '1);
    send_byte(8'h0F, 1'b0);
    send_byte(8'hF0, 1'b1);
    send_byte(8'hAA, 1'b1);
    settle();

    load_timing('0, '0, '0, 16'd1, 16'd1);
    send_byte(8'h55, 1'b1);
    settle();

    load_timing(16'd1, 16'd1, 16'd1, 16'd1, '0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    settle();

    load_timing(16'd24, 16'd8, 16'd16, 16'd32, 16'd16);
    run_bytes(60, 1'b1, 1'b0);
    settle();

    for (int p = 0; p < 4; p++) begin
      load_timing(pick_ticks(), pick_ticks(), pick_ticks(), pick_ticks(), pick_ticks());
      run_bytes(60, p != 1, p == 0);
      settle();
    end

    repeat (20) @(posedge clk_i);
    $display("Covered %0d bytes in %0d closed frames, %0d segments checked,",
             bytes_sent, board.frames_closed, board.segs_checked);
    $display("%0d timing settings, input backpressure seen: %0b",
             settings_used, saw_backpressure);
    if (board.errors == 0 && board.waiting() == 0) begin
      $display("pwm_frame_bit_transmitter regression: pass");
    end else begin
      $display("pwm_frame_bit_transmitter regression: fail");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/core/pwmt_pkg.sv
rtl/core/pwmt_cfg_regs.sv
rtl/core/pwmt_front.sv
rtl/core/pwmt_back.sv
rtl/core/pwm_frame_bit_transmitter.sv
verif/pwm_frame_bit_transmitter_test.sv
